// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Both macros expect a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, types and helpers for the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int MAP_BYTES = 4096;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAP_BYTES + 1);
  localparam int ID_W      = ADDR_W + 3;
  localparam int FREE_ID_W = 16;
  localparam int GID_W     = 15;
  localparam int STATUS_W  = 2;
  localparam int CMP_W     = FREE_ID_W + 1;
  localparam int ID_LIMIT  = MAP_BYTES * 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [7:0] BYTE_FULL = 8'hff;
  localparam logic [7:0] BIT0      = 8'h01;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [GID_W-1:0]    gid;
  } res_t;

  // Lowest clear bit of a byte; 7 when only bit 7 is clear (or none).
  function automatic logic [2:0] low_clear(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Fit a full identifier into the granted id field (truncate or extend).
  function automatic logic [GID_W-1:0] to_gid(input logic [ID_W-1:0] id);
    logic [ID_W+GID_W-1:0] t;
    t = {{GID_W{1'b0}}, id};
    return t[GID_W-1:0];
  endfunction

endpackage

// ----- rtl/bia_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bia_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ctrl
// Request sequencer: first-fit scan, free read-modify-write, fill tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bia_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [bia_pkg::FREE_ID_W-1:0]    free_id,
  input  logic                             out_free,
  output bia_pkg::mem_req_t                mem_req,
  input  logic [7:0]                       rd_data,
  output bia_pkg::res_t                    res
);
  import bia_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    fill, fill_next;        // bytes at or above read as zero
  logic [CNT_W-1:0]    scan_addr, scan_addr_next;
  logic [ADDR_W-1:0]   chk_addr, chk_addr_next;
  logic                chk_valid, chk_valid_next;
  logic [ADDR_W-1:0]   byte_r, byte_next;
  logic [2:0]          bit_r, bit_next;
  logic [STATUS_W-1:0] status_r, status_next;
  logic [GID_W-1:0]    gid_r, gid_next;

  logic       accept;
  logic [2:0] lc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign lc       = low_clear(rd_data);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    scan_addr_next = scan_addr;
    chk_addr_next  = chk_addr;
    chk_valid_next = chk_valid;
    byte_next      = byte_r;
    bit_next       = bit_r;
    status_next    = status_r;
    gid_next       = gid_r;
    mem_req        = '0;
    res            = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_FREE) begin
            status_next = ST_OK;
            gid_next    = '0;
            if (CMP_W'(free_id) >= CMP_W'(ID_LIMIT)) begin
              status_next = ST_RANGE;
              state_next  = S_RESP;
            end else if (CMP_W'(free_id[FREE_ID_W-1:3]) >= CMP_W'(fill)) begin
              // never written, already free
              state_next = S_RESP;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ADDR_W'(free_id[FREE_ID_W-1:3]);
              byte_next     = ADDR_W'(free_id[FREE_ID_W-1:3]);
              bit_next      = free_id[2:0];
              state_next    = S_FREE;
            end
          end else begin
            scan_addr_next = '0;
            chk_valid_next = 1'b0;
            state_next     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (chk_valid && rd_data != BYTE_FULL) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = chk_addr;
          mem_req.wdata = rd_data | (BIT0 << lc);
          status_next   = ST_OK;
          gid_next      = to_gid({chk_addr, lc});
          state_next    = S_RESP;
        end else if (scan_addr == fill) begin
          if (fill == CNT_W'(MAP_BYTES)) begin
            status_next = ST_FULL;
            gid_next    = '0;
          end else begin
            // first untouched byte: still all zero
            mem_req.we    = 1'b1;
            mem_req.waddr = fill[ADDR_W-1:0];
            mem_req.wdata = BIT0;
            fill_next     = fill + 1'b1;
            status_next   = ST_OK;
            gid_next      = to_gid({fill[ADDR_W-1:0], 3'd0});
          end
          state_next = S_RESP;
        end else begin
          mem_req.re     = 1'b1;
          mem_req.raddr  = scan_addr[ADDR_W-1:0];
          chk_addr_next  = scan_addr[ADDR_W-1:0];
          chk_valid_next = 1'b1;
          scan_addr_next = scan_addr + 1'b1;
        end
      end

      S_FREE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = byte_r;
        mem_req.wdata = rd_data & ~(BIT0 << bit_r);
        state_next    = S_RESP;
      end

      S_RESP: begin
        res.valid  = out_free;
        res.status = status_r;
        res.gid    = gid_r;
        if (out_free) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    chk_addr  <= chk_addr_next;
    byte_r    <= byte_next;
    bit_r     <= bit_next;
    status_r  <= status_next;
    gid_r     <= gid_next;
  end

  `ASSERT_ALWAYS(a_fill_bound, fill <= CNT_W'(MAP_BYTES), "fill count past map size")
  `ASSERT_ALWAYS(a_write_in_fill, !mem_req.we || CNT_W'(mem_req.waddr) <= fill, "write above fill")
  `ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted request left idle")

endmodule

// ----- rtl/bitmap_id_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// First-fit identifier allocator over a used-bit map held in block RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate reads the map one byte per
// cycle from byte 0 through the RAM read port and stops at the first byte
// that is not full; a full map reports status 1. A free does one read,
// one write back and one response, or the response alone when the id is
// out of range or its byte was never written. The map needs no clearing
// pass after reset: a fill count marks the bytes ever written, and bytes
// above it read as all free. The result sits in an output register, so a
// new request is taken while the previous result waits for the downstream
// side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_id_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [bia_pkg::FREE_ID_W-1:0]   free_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bia_pkg::STATUS_W-1:0]    status,
  output logic [bia_pkg::GID_W-1:0]       granted_id
);
  import bia_pkg::*;

  mem_req_t   mem_req;
  res_t       res;
  logic [7:0] rd_data;
  logic       out_free;

  // Output register can take a new result when empty or draining this cycle.
  assign out_free = !out_valid || !out_stall;

  bia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .free_id  (free_id),
    .out_free (out_free),
    .mem_req  (mem_req),
    .rd_data  (rd_data),
    .res      (res)
  );

  // Used-bit map, eight identifiers per byte, LSB first.
  bia_ram #(
    .DEPTH (MAP_BYTES),
    .WIDTH (8)
  ) u_map (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status     <= res.status;
      granted_id <= res.gid;
    end
  end

  `ASSERT_ALWAYS(a_status_code, !out_valid || status == ST_OK || status == ST_FULL || status == ST_RANGE, "bad status code")
  `ASSERT_ALWAYS(a_gid_zero, !out_valid || status == ST_OK || granted_id == '0, "nonzero id on failure")
  `ASSERT_ALWAYS(a_no_overwrite, !(res.valid && out_valid && out_stall), "result overwrote pending result")

endmodule
